// ===== rtl/core/hcv_pkg.sv =====
package hcv_pkg;

    // Field and register widths.
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 4;
    localparam int REG_W       = 12;
    localparam int HSV_W       = 8;
    localparam int COORD_W     = 11;
    localparam int CODE_W      = 3;
    localparam int OUT_VOTE_W  = 22;
    localparam int NUM_CLASSES = 5;

    // Largest coordinate bound a region register may hold.
    localparam int COORD_LIMIT = 2048;

    localparam int VOTE_BITS_DEFAULT = 22;

    localparam logic [REG_W-1:0] REGION_BOUND_RESET = REG_W'(2048);

    // Class thresholds on hue, saturation and brightness.
    localparam logic [HSV_W-1:0] RED_HUE_LOW_MAX  = 8'd15;
    localparam logic [HSV_W-1:0] RED_HUE_HIGH_MIN = 8'd170;
    localparam logic [HSV_W-1:0] HUE_MAX          = 8'd180;
    localparam logic [HSV_W-1:0] YELLOW_HUE_MIN   = 8'd20;
    localparam logic [HSV_W-1:0] YELLOW_HUE_MAX   = 8'd30;
    localparam logic [HSV_W-1:0] YELLOW_SAT_MIN   = 8'd10;
    localparam logic [HSV_W-1:0] BLUE_HUE_MIN     = 8'd110;
    localparam logic [HSV_W-1:0] BLUE_HUE_MAX     = 8'd115;
    localparam logic [HSV_W-1:0] BLUE_VAL_MIN     = 8'd50;
    localparam logic [HSV_W-1:0] MID_SAT_MIN      = 8'd40;
    localparam logic [HSV_W-1:0] MID_SAT_MAX      = 8'd100;
    localparam logic [HSV_W-1:0] DIM_VAL_MAX      = 8'd100;
    localparam logic [HSV_W-1:0] WHITE_VAL_MIN    = 8'd200;
    localparam logic [HSV_W-1:0] BLACK_VAL_MAX    = 8'd15;

    typedef enum logic [1:0] {
        REG_LEFT   = 2'd0,
        REG_TOP    = 2'd1,
        REG_RIGHT  = 2'd2,
        REG_BOTTOM = 2'd3
    } reg_index_t;

    typedef enum logic [CODE_W-1:0] {
        CLS_WHITE  = 3'd0,
        CLS_RED    = 3'd1,
        CLS_YELLOW = 3'd2,
        CLS_BLUE   = 3'd3,
        CLS_BLACK  = 3'd4
    } class_t;

    typedef struct packed {
        logic [REG_W-1:0] left;
        logic [REG_W-1:0] top;
        logic [REG_W-1:0] right;
        logic [REG_W-1:0] bottom;
    } region_t;

    // One classified pixel on its way to the vote counters.
    typedef struct packed {
        logic   valid;
        logic   last;
        logic   hit;
        class_t cls;
    } vote_t;

endpackage

// ===== rtl/core/hcv_regs.sv =====
module hcv_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hcv_pkg::ADDR_W-1:0]   paddr,
    input  logic [hcv_pkg::DATA_W-1:0]   pwdata,
    output logic [hcv_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output hcv_pkg::region_t             region
);

    localparam int LIMIT_W = $clog2(hcv_pkg::COORD_LIMIT + 1);
    localparam int CW = (hcv_pkg::REG_W > LIMIT_W) ? hcv_pkg::REG_W : LIMIT_W;

    hcv_pkg::region_t            region_reg;
    hcv_pkg::region_t            region_next;
    hcv_pkg::reg_index_t         index;
    logic                        wr_en;
    logic [CW-1:0]               wr_wide;
    logic [hcv_pkg::REG_W-1:0]   wr_value;
    logic [hcv_pkg::REG_W-1:0]   rd_value;

    assign index   = hcv_pkg::reg_index_t'(paddr[hcv_pkg::ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign wr_wide = CW'(pwdata[hcv_pkg::REG_W-1:0]);

    // Values above the coordinate limit (low REG_W bits of pwdata) are clamped to it.
    assign wr_value = (wr_wide > CW'(hcv_pkg::COORD_LIMIT)) ?
                      hcv_pkg::REG_W'(hcv_pkg::COORD_LIMIT) :
                      pwdata[hcv_pkg::REG_W-1:0];

    always_comb
    begin
        region_next = region_reg;
        if (wr_en)
        begin
            case (index)
                hcv_pkg::REG_LEFT:   region_next.left   = wr_value;
                hcv_pkg::REG_TOP:    region_next.top    = wr_value;
                hcv_pkg::REG_RIGHT:  region_next.right  = wr_value;
                hcv_pkg::REG_BOTTOM: region_next.bottom = wr_value;
                default:             region_next = region_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg.left   <= '0;
            region_reg.top    <= '0;
            region_reg.right  <= hcv_pkg::REGION_BOUND_RESET;
            region_reg.bottom <= hcv_pkg::REGION_BOUND_RESET;
        end
        else
        begin
            region_reg <= region_next;
        end
    end

    always_comb
    begin
        case (index)
            hcv_pkg::REG_LEFT:   rd_value = region_reg.left;
            hcv_pkg::REG_TOP:    rd_value = region_reg.top;
            hcv_pkg::REG_RIGHT:  rd_value = region_reg.right;
            hcv_pkg::REG_BOTTOM: rd_value = region_reg.bottom;
            default:             rd_value = '0;
        endcase
    end

    assign prdata = {{(hcv_pkg::DATA_W - hcv_pkg::REG_W){1'b0}}, rd_value};
    assign pready = 1'b1;
    assign region = region_reg;

endmodule

// ===== rtl/core/hcv_classify.sv =====
module hcv_classify
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [hcv_pkg::HSV_W-1:0]   hue,
    input  logic [hcv_pkg::HSV_W-1:0]   saturation,
    input  logic [hcv_pkg::HSV_W-1:0]   brightness,
    input  logic [hcv_pkg::COORD_W-1:0] column,
    input  logic [hcv_pkg::COORD_W-1:0] row,
    input  logic                        last_pixel,
    input  hcv_pkg::region_t            region,
    output hcv_pkg::vote_t              vote,
    input  logic                        vote_take
);

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [hcv_pkg::HSV_W-1:0]   hue_reg;
    logic [hcv_pkg::HSV_W-1:0]   sat_reg;
    logic [hcv_pkg::HSV_W-1:0]   val_reg;
    logic [hcv_pkg::COORD_W-1:0] col_reg;
    logic [hcv_pkg::COORD_W-1:0] row_reg;
    logic                        last_reg;

    logic                        s2_valid_reg;
    logic                        s2_valid_next;
    logic                        s2_last_reg;
    logic                        s2_hit_reg;
    hcv_pkg::class_t             s2_cls_reg;

    logic                        s1_load;
    logic                        s2_load;
    logic [hcv_pkg::REG_W-1:0]   col_wide;
    logic [hcv_pkg::REG_W-1:0]   row_wide;
    logic                        in_region;
    logic                        sat_mid;
    logic                        hit;
    hcv_pkg::class_t             cls;

    // Each stage moves when it is empty or its item moves on.
    assign s2_load  = !s2_valid_reg || vote_take;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_stall = !s1_load;

    assign s1_valid_next = s1_load ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_load ? s1_valid_reg : s2_valid_reg;

    assign col_wide  = hcv_pkg::REG_W'(col_reg);
    assign row_wide  = hcv_pkg::REG_W'(row_reg);
    assign in_region = (col_wide >= region.left) && (col_wide < region.right) &&
                       (row_wide >= region.top) && (row_wide < region.bottom);
    assign sat_mid   = (sat_reg >= hcv_pkg::MID_SAT_MIN) && (sat_reg <= hcv_pkg::MID_SAT_MAX);

    // Class tests in priority order; the first that matches wins.
    always_comb
    begin
        hit = in_region;
        cls = hcv_pkg::CLS_WHITE;
        if ((hue_reg <= hcv_pkg::RED_HUE_LOW_MAX) && sat_mid &&
            (val_reg <= hcv_pkg::DIM_VAL_MAX))
        begin
            cls = hcv_pkg::CLS_RED;
        end
        else if ((hue_reg >= hcv_pkg::RED_HUE_HIGH_MIN) && (hue_reg <= hcv_pkg::HUE_MAX) &&
                 sat_mid && (val_reg <= hcv_pkg::DIM_VAL_MAX))
        begin
            cls = hcv_pkg::CLS_RED;
        end
        else if ((hue_reg >= hcv_pkg::YELLOW_HUE_MIN) && (hue_reg <= hcv_pkg::YELLOW_HUE_MAX) &&
                 (sat_reg >= hcv_pkg::YELLOW_SAT_MIN))
        begin
            cls = hcv_pkg::CLS_YELLOW;
        end
        else if ((hue_reg >= hcv_pkg::BLUE_HUE_MIN) && (hue_reg <= hcv_pkg::BLUE_HUE_MAX) &&
                 sat_mid && (val_reg >= hcv_pkg::BLUE_VAL_MIN) &&
                 (val_reg <= hcv_pkg::DIM_VAL_MAX))
        begin
            cls = hcv_pkg::CLS_BLUE;
        end
        else if ((hue_reg <= hcv_pkg::HUE_MAX) && (val_reg >= hcv_pkg::WHITE_VAL_MIN))
        begin
            cls = hcv_pkg::CLS_WHITE;
        end
        else if ((hue_reg <= hcv_pkg::HUE_MAX) && (val_reg <= hcv_pkg::BLACK_VAL_MAX))
        begin
            cls = hcv_pkg::CLS_BLACK;
        end
        else
        begin
            hit = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            hue_reg  <= hue;
            sat_reg  <= saturation;
            val_reg  <= brightness;
            col_reg  <= column;
            row_reg  <= row;
            last_reg <= last_pixel;
        end
        if (s2_load)
        begin
            s2_last_reg <= last_reg;
            s2_hit_reg  <= hit;
            s2_cls_reg  <= cls;
        end
    end

    assign vote.valid = s2_valid_reg;
    assign vote.last  = s2_last_reg;
    assign vote.hit   = s2_hit_reg;
    assign vote.cls   = s2_cls_reg;

endmodule

// ===== rtl/core/hcv_votes.sv =====
module hcv_votes
#(
    parameter int VOTE_BITS = hcv_pkg::VOTE_BITS_DEFAULT
)
(
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  hcv_pkg::vote_t                                   vote,
    output logic                                             vote_take,
    output logic                                             snap_valid,
    output logic [hcv_pkg::NUM_CLASSES-1:0][VOTE_BITS-1:0]   snap,
    input  logic                                             snap_ready
);

    localparam logic [VOTE_BITS-1:0] VOTE_MAX = {VOTE_BITS{1'b1}};

    logic [hcv_pkg::NUM_CLASSES-1:0][VOTE_BITS-1:0] cnt_reg;
    logic [hcv_pkg::NUM_CLASSES-1:0][VOTE_BITS-1:0] cnt_next;
    logic [hcv_pkg::NUM_CLASSES-1:0][VOTE_BITS-1:0] snap_reg;
    logic [hcv_pkg::NUM_CLASSES-1:0][VOTE_BITS-1:0] snap_next;
    logic [hcv_pkg::NUM_CLASSES-1:0][VOTE_BITS-1:0] bumped;
    logic                                           snap_valid_reg;
    logic                                           snap_valid_next;
    logic                                           take_last;

    // A last item needs the snapshot register free; other items always go in.
    assign vote_take = vote.valid && (!vote.last || !snap_valid_reg || snap_ready);
    assign take_last = vote_take && vote.last;

    always_comb
    begin
        for (int i = 0; i < hcv_pkg::NUM_CLASSES; i++)
        begin
            bumped[i] = cnt_reg[i];
            if (vote.hit && (vote.cls == hcv_pkg::class_t'(hcv_pkg::CODE_W'(i))) &&
                (cnt_reg[i] != VOTE_MAX))
            begin
                bumped[i] = cnt_reg[i] + 1'b1;
            end
        end
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        snap_next       = snap_reg;
        snap_valid_next = snap_valid_reg && !snap_ready;
        if (vote_take)
        begin
            if (vote.last)
            begin
                snap_next       = bumped;
                cnt_next        = '0;
                snap_valid_next = 1'b1;
            end
            else
            begin
                cnt_next = bumped;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

`ifndef SYNTHESIS
    a_last_fills_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
        take_last |=> snap_valid_reg)
        else $error("last item taken but no snapshot held");

    a_last_clears_counters: assert property (@(posedge clk) disable iff (!rst_n)
        take_last |=> (cnt_reg == '0))
        else $error("vote counters not cleared after last item");

    a_snapshot_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (snap_valid_reg && !snap_ready) |=> (snap_valid_reg && $stable(snap_reg)))
        else $error("waiting snapshot changed");
`endif

endmodule

// ===== rtl/core/hcv_argmax.sv =====
module hcv_argmax
#(
    parameter int VOTE_BITS = hcv_pkg::VOTE_BITS_DEFAULT
)
(
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             snap_valid,
    input  logic [hcv_pkg::NUM_CLASSES-1:0][VOTE_BITS-1:0]   snap,
    output logic                                             snap_ready,
    output logic                                             out_valid,
    input  logic                                             out_stall,
    output logic [hcv_pkg::CODE_W-1:0]                       color_code,
    output logic [hcv_pkg::OUT_VOTE_W-1:0]                   winning_votes
);

    localparam int WIDE_W = (VOTE_BITS > hcv_pkg::OUT_VOTE_W) ? VOTE_BITS : hcv_pkg::OUT_VOTE_W;
    localparam logic [hcv_pkg::OUT_VOTE_W-1:0] OUT_MAX = {hcv_pkg::OUT_VOTE_W{1'b1}};

    logic                             pair_valid_reg;
    logic                             pair_valid_next;
    hcv_pkg::class_t                  w01_idx_reg;
    logic [VOTE_BITS-1:0]             w01_cnt_reg;
    hcv_pkg::class_t                  w23_idx_reg;
    logic [VOTE_BITS-1:0]             w23_cnt_reg;
    logic [VOTE_BITS-1:0]             c4_reg;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [hcv_pkg::CODE_W-1:0]       color_code_reg;
    logic [hcv_pkg::OUT_VOTE_W-1:0]   winning_votes_reg;

    logic                             out_load;
    hcv_pkg::class_t                  mid_idx;
    logic [VOTE_BITS-1:0]             mid_cnt;
    hcv_pkg::class_t                  best_idx;
    logic [VOTE_BITS-1:0]             best_cnt;
    logic [WIDE_W-1:0]                best_wide;

    assign out_load   = !out_valid_reg || !out_stall;
    assign snap_ready = !pair_valid_reg || out_load;

    assign pair_valid_next = snap_ready ? snap_valid : pair_valid_reg;
    assign out_valid_next  = out_load ? pair_valid_reg : out_valid_reg;

    // Second level of the compare tree; a later class wins only on a strictly
    // larger count, so ties stay with the lower index.
    always_comb
    begin
        if (w23_cnt_reg > w01_cnt_reg)
        begin
            mid_idx = w23_idx_reg;
            mid_cnt = w23_cnt_reg;
        end
        else
        begin
            mid_idx = w01_idx_reg;
            mid_cnt = w01_cnt_reg;
        end
        if (c4_reg > mid_cnt)
        begin
            best_idx = hcv_pkg::CLS_BLACK;
            best_cnt = c4_reg;
        end
        else
        begin
            best_idx = mid_idx;
            best_cnt = mid_cnt;
        end
    end

    assign best_wide = WIDE_W'(best_cnt);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pair_valid_reg <= pair_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_ready)
        begin
            if (snap[1] > snap[0])
            begin
                w01_idx_reg <= hcv_pkg::CLS_RED;
                w01_cnt_reg <= snap[1];
            end
            else
            begin
                w01_idx_reg <= hcv_pkg::CLS_WHITE;
                w01_cnt_reg <= snap[0];
            end
            if (snap[3] > snap[2])
            begin
                w23_idx_reg <= hcv_pkg::CLS_BLUE;
                w23_cnt_reg <= snap[3];
            end
            else
            begin
                w23_idx_reg <= hcv_pkg::CLS_YELLOW;
                w23_cnt_reg <= snap[2];
            end
            c4_reg <= snap[4];
        end
        if (out_load)
        begin
            color_code_reg <= best_idx;
            if (best_wide > WIDE_W'(OUT_MAX))
            begin
                winning_votes_reg <= OUT_MAX;
            end
            else
            begin
                winning_votes_reg <= best_wide[hcv_pkg::OUT_VOTE_W-1:0];
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign color_code    = color_code_reg;
    assign winning_votes = winning_votes_reg;

endmodule

// ===== rtl/core/hsv_color_vote_classifier.sv =====
// A last pixel's result passes the classify, snapshot, tree and output registers in order.
// Throughput: one pixel item per cycle; the input register, classify stage and vote counters
// run every cycle unless a last pixel must wait behind an earlier result still in the tree.
// Reset (rst_n low, asynchronous) empties the pipeline, zeros all vote counters and sets the
// region registers to left 0, top 0, right 2048, bottom 2048.
module hsv_color_vote_classifier
#(
    parameter int VOTE_BITS = hcv_pkg::VOTE_BITS_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hcv_pkg::ADDR_W-1:0]     paddr,
    input  logic [hcv_pkg::DATA_W-1:0]     pwdata,
    output logic [hcv_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [hcv_pkg::HSV_W-1:0]      hue,
    input  logic [hcv_pkg::HSV_W-1:0]      saturation,
    input  logic [hcv_pkg::HSV_W-1:0]      brightness,
    input  logic [hcv_pkg::COORD_W-1:0]    column,
    input  logic [hcv_pkg::COORD_W-1:0]    row,
    input  logic                           last_pixel,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [hcv_pkg::CODE_W-1:0]     color_code,
    output logic [hcv_pkg::OUT_VOTE_W-1:0] winning_votes
);

    // The datapath is a short pipeline of registered stages:
    //   1. input register holding the pixel item,
    //   2. classify register: region test and the prioritized color tests,
    //   3. vote counters, plus a snapshot of the final counts on a last pixel,
    //   4. first level of the arg-max tree (white/red, yellow/blue, black),
    //   5. output register with the winner and its saturated count.
    // Pixels without the last mark end at the counters, so they never block on
    // the output side. A last pixel clears the counters as it takes its
    // snapshot, so the next frame can start voting in the following cycle.

    hcv_pkg::region_t                                region;
    hcv_pkg::vote_t                                  vote;
    logic                                            vote_take;
    logic                                            snap_valid;
    logic [hcv_pkg::NUM_CLASSES-1:0][VOTE_BITS-1:0]  snap;
    logic                                            snap_ready;

    hcv_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .region  (region)
    );

    hcv_classify u_classify
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .column     (column),
        .row        (row),
        .last_pixel (last_pixel),
        .region     (region),
        .vote       (vote),
        .vote_take  (vote_take)
    );

    hcv_votes #(.VOTE_BITS(VOTE_BITS)) u_votes
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .vote       (vote),
        .vote_take  (vote_take),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready)
    );

    hcv_argmax #(.VOTE_BITS(VOTE_BITS)) u_argmax
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .snap_valid    (snap_valid),
        .snap          (snap),
        .snap_ready    (snap_ready),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .color_code    (color_code),
        .winning_votes (winning_votes)
    );

endmodule
